@@ rtl/core/gbfs_pkg.sv @@
// gbfs_pkg: shared constants, operation codes and state type
// for the graph search block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gbfs_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = 6;
  localparam int CNT_W        = 7;   // vertex count register, holds 0..127
  localparam int WEIGHT_BITS  = 16;
  localparam int EDGE_W       = 13;
  localparam int WADDR_W      = 2 * VTX_W;
  localparam int WDEPTH       = MAX_VERTICES * MAX_VERTICES;

  localparam logic [2:0] OP_SET   = 3'd0;
  localparam logic [2:0] OP_DEL   = 3'd1;
  localparam logic [2:0] OP_QUERY = 3'd2;
  localparam logic [2:0] OP_SRCH  = 3'd3;
  localparam logic [2:0] OP_PRED  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDIT,
    S_PRED,
    S_POP,
    S_POPW,
    S_ROW,
    S_SCAN
  } state_t;
endpackage
`default_nettype wire

@@ rtl/core/gbfs_ram.sv @@
// gbfs_ram: generic single write port, single read port ram
// with registered read; no dependencies
`timescale 1ns / 1ps
`default_nettype none
module gbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/graph_bfs_path_search.sv @@
// graph_bfs_path_search: directed weighted graph store with breadth-first search
// depends on gbfs_pkg and gbfs_ram
`timescale 1ns / 1ps
`default_nettype none
// One word in, one word out. A word is taken when start is high and busy is
// low; its result shows on the out_ ports for one cycle with out_strobe and
// cannot be held off, so it must be captured then. Edge set, delete and query
// read the row and weight and answer from S_EDIT; read predecessor answers from
// S_PRED; out-of-range and unused operations answer straight from idle. A search
// seeds the queue with the source, then for every dequeued vertex fetches its
// adjacency row (S_POP, S_POPW, S_ROW), scans it one active vertex a cycle and
// closes the scan, until the destination is hit or the queue drains; its time is
// set by the single adjacency memory read port and the one-vertex-a-cycle scan.
// Adjacency rows and predecessors read as zero until first written (per-row
// and per-entry valid flops, cleared at reset), so no clearing pass is needed.
// cfg_wdata sets the active vertex count, clamped to 1..64.
module graph_bfs_path_search
  import gbfs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [2:0]             in_operation,
  input  wire logic [VTX_W-1:0]       in_from_vertex,
  input  wire logic [VTX_W-1:0]       in_to_vertex,
  input  wire logic [WEIGHT_BITS-1:0] in_edge_weight,
  input  wire logic                   cfg_we,
  input  wire logic [CNT_W-1:0]       cfg_wdata,
  output logic                        out_strobe,
  output logic                        out_status,
  output logic                        out_path_found,
  output logic                        out_edge_present,
  output logic [WEIGHT_BITS-1:0]      out_weight_out,
  output logic [VTX_W-1:0]            out_predecessor,
  output logic [EDGE_W-1:0]           out_total_edges
);
  state_t state_r, state_nxt;

  // configuration and latched command word
  logic [CNT_W-1:0]       vcnt_r;
  logic [CNT_W-1:0]       n_act;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [VTX_W-1:0]       f_r, f_nxt, t_r, t_nxt;
  logic [WEIGHT_BITS-1:0] w_r, w_nxt;

  // graph state
  logic [EDGE_W-1:0]       cnt_r, cnt_nxt;
  logic [MAX_VERTICES-1:0] adj_vld_r, adj_vld_nxt;
  logic [MAX_VERTICES-1:0] rt_vld_r, rt_vld_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;

  // search walk
  logic [CNT_W-1:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]        v_r, v_nxt;
  logic [VTX_W-1:0]        u_r, u_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt;

  // result registers
  logic                   strobe_r, strobe_nxt;
  logic                   stat_r, stat_nxt;
  logic                   found_r, found_nxt;
  logic                   pres_r, pres_nxt;
  logic [WEIGHT_BITS-1:0] wout_r, wout_nxt;
  logic [VTX_W-1:0]       pred_r, pred_nxt;
  logic [EDGE_W-1:0]      tot_r, tot_nxt;

  // memory ports
  logic                    adj_we;
  logic [VTX_W-1:0]        adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    wt_we;
  logic [WEIGHT_BITS-1:0]  wt_rdata;
  logic                    rt_we;
  logic [VTX_W-1:0]        rt_waddr, rt_wdata, rt_rdata;
  logic                    q_we;
  logic [VTX_W-1:0]        q_waddr, q_wdata, q_rdata;

  logic                    accept;
  logic                    bad_ft, bad_f;
  logic [MAX_VERTICES-1:0] row_cur;
  logic                    hit;

  gbfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  // weight store, addressed by {from, to}
  gbfs_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(WDEPTH)) u_wt (
    .clk(clk), .we(wt_we), .waddr({f_r, t_r}), .wdata(w_r),
    .raddr({in_from_vertex, in_to_vertex}), .rdata(wt_rdata)
  );

  // predecessor store
  gbfs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_rt (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .raddr(in_from_vertex), .rdata(rt_rdata)
  );

  // frontier fifo, never wraps within one search
  gbfs_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_q (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[VTX_W-1:0]), .rdata(q_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // clamp the configured vertex count to 1..MAX_VERTICES
  always_comb begin
    priority if (vcnt_r == '0) begin
      n_act = CNT_W'(1);
    end else if (vcnt_r > CNT_W'(MAX_VERTICES)) begin
      n_act = CNT_W'(MAX_VERTICES);
    end else begin
      n_act = vcnt_r;
    end
  end

  assign bad_f  = ({1'b0, in_from_vertex} >= n_act);
  assign bad_ft = bad_f || ({1'b0, in_to_vertex} >= n_act);

  // adjacency row of the word's source, zero if never written
  assign row_cur = adj_rdata & {MAX_VERTICES{adj_vld_r[f_r]}};
  assign hit     = row_r[v_r[VTX_W-1:0]] && !vis_r[v_r[VTX_W-1:0]];

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    op_nxt      = op_r;
    f_nxt       = f_r;
    t_nxt       = t_r;
    w_nxt       = w_r;
    cnt_nxt     = cnt_r;
    adj_vld_nxt = adj_vld_r;
    rt_vld_nxt  = rt_vld_r;
    vis_nxt     = vis_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    v_nxt       = v_r;
    u_nxt       = u_r;
    row_nxt     = row_r;
    strobe_nxt  = 1'b0;
    stat_nxt    = stat_r;
    found_nxt   = found_r;
    pres_nxt    = pres_r;
    wout_nxt    = wout_r;
    pred_nxt    = pred_r;
    tot_nxt     = tot_r;

    adj_we    = 1'b0;
    adj_waddr = f_r;
    adj_wdata = row_cur;
    adj_raddr = in_from_vertex;
    wt_we     = 1'b0;
    rt_we     = 1'b0;
    rt_waddr  = in_from_vertex;
    rt_wdata  = in_from_vertex;
    q_we      = 1'b0;
    q_waddr   = tail_r[VTX_W-1:0];
    q_wdata   = in_from_vertex;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_operation;
          f_nxt     = in_from_vertex;
          t_nxt     = in_to_vertex;
          w_nxt     = in_edge_weight;
          n_nxt     = n_act;
          // default quick answer: all zero but the edge total
          stat_nxt  = 1'b0;
          found_nxt = 1'b0;
          pres_nxt  = 1'b0;
          wout_nxt  = '0;
          pred_nxt  = '0;
          tot_nxt   = cnt_r;
          priority if (in_operation <= OP_SRCH && bad_ft) begin
            stat_nxt   = 1'b1;
            strobe_nxt = 1'b1;
          end else if (in_operation == OP_SRCH) begin
            // seed: source visited, its own predecessor, first in queue
            vis_nxt  = '0;
            vis_nxt[in_from_vertex] = 1'b1;
            rt_we    = 1'b1;
            rt_vld_nxt[in_from_vertex] = 1'b1;
            q_we     = 1'b1;
            q_waddr  = '0;
            head_nxt = '0;
            tail_nxt = CNT_W'(1);
            state_nxt = S_POP;
          end else if (in_operation <= OP_QUERY) begin
            state_nxt = S_EDIT;
          end else if (in_operation == OP_PRED) begin
            if (bad_f) begin
              stat_nxt   = 1'b1;
              strobe_nxt = 1'b1;
            end else begin
              state_nxt = S_PRED;
            end
          end else begin
            strobe_nxt = 1'b1;
          end
        end
      end

      S_EDIT: begin
        // row and weight read data arrive here
        adj_waddr = f_r;
        adj_wdata = row_cur;
        unique case (op_r)
          OP_SET: begin
            adj_wdata[t_r] = 1'b1;
            adj_we = 1'b1;
            adj_vld_nxt[f_r] = 1'b1;
            wt_we = 1'b1;
            if (!row_cur[t_r]) begin
              cnt_nxt = cnt_r + EDGE_W'(1);
            end
          end
          OP_DEL: begin
            if (row_cur[t_r]) begin
              adj_wdata[t_r] = 1'b0;
              adj_we  = 1'b1;
              cnt_nxt = cnt_r - EDGE_W'(1);
            end
          end
          default: begin
            pres_nxt = row_cur[t_r];
            wout_nxt = row_cur[t_r] ? wt_rdata : '0;
          end
        endcase
        tot_nxt    = cnt_nxt;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end

      S_PRED: begin
        pred_nxt   = rt_vld_r[f_r] ? rt_rdata : '0;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end

      S_POP: begin
        if (head_r < tail_r) begin
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = S_POPW;
        end else begin
          // queue drained without reaching the destination
          found_nxt  = 1'b0;
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      S_POPW: begin
        u_nxt     = q_rdata;
        adj_raddr = q_rdata;
        state_nxt = S_ROW;
      end

      S_ROW: begin
        row_nxt   = adj_rdata & {MAX_VERTICES{adj_vld_r[u_r]}};
        v_nxt     = '0;
        state_nxt = S_SCAN;
      end

      S_SCAN: begin
        if (v_r == n_r) begin
          state_nxt = S_POP;
        end else begin
          v_nxt = v_r + CNT_W'(1);
          if (hit) begin
            vis_nxt[v_r[VTX_W-1:0]] = 1'b1;
            rt_we    = 1'b1;
            rt_waddr = v_r[VTX_W-1:0];
            rt_wdata = u_r;
            rt_vld_nxt[v_r[VTX_W-1:0]] = 1'b1;
            if (v_r[VTX_W-1:0] == t_r) begin
              found_nxt  = 1'b1;
              strobe_nxt = 1'b1;
              state_nxt  = S_IDLE;
            end else if (tail_r < CNT_W'(MAX_VERTICES)) begin
              q_we     = 1'b1;
              q_waddr  = tail_r[VTX_W-1:0];
              q_wdata  = v_r[VTX_W-1:0];
              tail_nxt = tail_r + CNT_W'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vcnt_r    <= CNT_W'(MAX_VERTICES);
      cnt_r     <= '0;
      adj_vld_r <= '0;
      rt_vld_r  <= '0;
      vis_r     <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        vcnt_r <= cfg_wdata;
      end
      cnt_r     <= cnt_nxt;
      adj_vld_r <= adj_vld_nxt;
      rt_vld_r  <= rt_vld_nxt;
      vis_r     <= vis_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    op_r    <= op_nxt;
    f_r     <= f_nxt;
    t_r     <= t_nxt;
    w_r     <= w_nxt;
    v_r     <= v_nxt;
    u_r     <= u_nxt;
    row_r   <= row_nxt;
    stat_r  <= stat_nxt;
    found_r <= found_nxt;
    pres_r  <= pres_nxt;
    wout_r  <= wout_nxt;
    pred_r  <= pred_nxt;
    tot_r   <= tot_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_status       = stat_r;
  assign out_path_found   = found_r;
  assign out_edge_present = pres_r;
  assign out_weight_out   = wout_r;
  assign out_predecessor  = pred_r;
  assign out_total_edges  = tot_r;

`ifndef NO_ASSERTIONS
  // a result word only appears once the block is back to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word while busy");

  // queue read pointer never passes the write pointer
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r <= tail_r) && (tail_r <= CNT_W'(MAX_VERTICES)))
    else $error("frontier queue pointers out of order");

  // edge count bounded by the table size
  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EDGE_W'(WDEPTH))
    else $error("edge count overflow");
`endif
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for graph_bfs_path_search (directed graph, bfs)
// depends on gbfs_pkg and the rtl of the block; the scoreboard class lives here
`timescale 1ns / 1ps

module tb_top;
  import gbfs_pkg::*;

  localparam logic [2:0] OP_SPARE_LO  = 3'd5;  // 5..7 are unused codes
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  localparam int         IDLE_LIMIT   = 20000; // well above the worst search time

  // one result word, fields as they show on the out_ ports
  typedef struct packed {
    logic                   status;
    logic                   path_found;
    logic                   edge_present;
    logic [WEIGHT_BITS-1:0] weight_out;
    logic [VTX_W-1:0]       predecessor;
    logic [EDGE_W-1:0]      total_edges;
  } answer_t;

  // graph shadow plus the queue of answers still owed by the block
  class graph_scoreboard;
    logic [63:0]            adj_rows[MAX_VERTICES];
    logic [WEIGHT_BITS-1:0] weights[MAX_VERTICES][MAX_VERTICES];
    logic [VTX_W-1:0]       parent_of[MAX_VERTICES];
    logic [EDGE_W-1:0]      edge_count;
    logic [CNT_W-1:0]       vertex_reg;
    answer_t                owed[$];
    int                     errors, checked, found_paths, op_seen[8];

    function new();
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj_rows[i]  = '0;
        parent_of[i] = '0;
      end
      edge_count = '0;
      vertex_reg = 7'd64;
    endfunction

    function int active_vertices();
      if (vertex_reg < 1) return 1;
      if (vertex_reg > MAX_VERTICES) return MAX_VERTICES;
      return vertex_reg;
    endfunction

    // breadth-first walk, neighbours in ascending order, stops at first hit
    function logic walk_graph(int src, int dst, int n);
      logic [63:0] seen;
      int          frontier[$];
      int          u;
      seen = '0;
      seen[src] = 1'b1;
      parent_of[src] = src[VTX_W-1:0];
      frontier.push_back(src);
      while (frontier.size() > 0) begin
        u = frontier.pop_front();
        for (int v = 0; v < n; v++) begin
          if (adj_rows[u][v] && !seen[v]) begin
            seen[v] = 1'b1;
            parent_of[v] = u[VTX_W-1:0];
            if (v == dst) return 1'b1;
            frontier.push_back(v);
          end
        end
      end
      return 1'b0;
    endfunction

    // accepted input word: update the shadow and queue its answer
    function void note_word(logic [2:0] op, logic [VTX_W-1:0] f, logic [VTX_W-1:0] t,
                            logic [WEIGHT_BITS-1:0] w);
      answer_t a;
      int      n;
      a = '0;
      n = active_vertices();
      op_seen[op]++;
      if (op <= OP_SRCH) begin
        if (f >= n || t >= n) begin
          a.status = 1'b1;
        end else if (op == OP_SET) begin
          if (!adj_rows[f][t]) begin
            adj_rows[f][t] = 1'b1;
            edge_count++;
          end
          weights[f][t] = w;
        end else if (op == OP_DEL) begin
          if (adj_rows[f][t]) begin
            adj_rows[f][t] = 1'b0;
            edge_count--;
          end
        end else if (op == OP_QUERY) begin
          if (adj_rows[f][t]) begin
            a.edge_present = 1'b1;
            a.weight_out   = weights[f][t];
          end
        end else begin
          a.path_found = walk_graph(f, t, n);
          found_paths += a.path_found;
        end
      end else if (op == OP_PRED) begin
        if (f >= n) a.status = 1'b1;
        else a.predecessor = parent_of[f];
      end
      a.total_edges = edge_count;
      owed.push_back(a);
    endfunction

    function void field_diff(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // result strobe: compare against the oldest owed answer
    function void check_word(answer_t got);
      answer_t e;
      if (owed.size() == 0) begin
        $display("%0t unexpected result word: actual %p", $time, got);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      field_diff("status",       e.status,       got.status);
      field_diff("path_found",   e.path_found,   got.path_found);
      field_diff("edge_present", e.edge_present, got.edge_present);
      field_diff("weight_out",   e.weight_out,   got.weight_out);
      field_diff("predecessor",  e.predecessor,  got.predecessor);
      field_diff("total_edges",  e.total_edges,  got.total_edges);
    endfunction
  endclass

  logic                   clk, rst_n, start, busy, cfg_we;
  logic [2:0]             in_operation;
  logic [VTX_W-1:0]       in_from_vertex, in_to_vertex;
  logic [WEIGHT_BITS-1:0] in_edge_weight;
  logic [CNT_W-1:0]       cfg_wdata;
  logic                   out_strobe, out_status, out_path_found, out_edge_present;
  logic [WEIGHT_BITS-1:0] out_weight_out;
  logic [VTX_W-1:0]       out_predecessor;
  logic [EDGE_W-1:0]      out_total_edges;

  graph_scoreboard sb = new();
  int              idle_cycles;
  int              burst_left;

  graph_bfs_path_search dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_from_vertex(in_from_vertex),
    .in_to_vertex(in_to_vertex), .in_edge_weight(in_edge_weight),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_strobe(out_strobe), .out_status(out_status), .out_path_found(out_path_found),
    .out_edge_present(out_edge_present), .out_weight_out(out_weight_out),
    .out_predecessor(out_predecessor), .out_total_edges(out_total_edges)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor: results are checked before the same edge's input word is noted,
  // so an answer never gets matched against a word taken in the same cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_word({out_status, out_path_found, out_edge_present,
                       out_weight_out, out_predecessor, out_total_edges});
      if (cfg_we) sb.vertex_reg = cfg_wdata;
      if (start && !busy)
        sb.note_word(in_operation, in_from_vertex, in_to_vertex, in_edge_weight);
      // watchdog: a long stretch with no word moving either way is a hang
      if (out_strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // present one word and hold it until the block takes it; the caller is at
  // a rising edge and start stays high on return so back-to-back words work
  task automatic send_word(logic [2:0] op, int f, int t, int w);
    start          <= 1'b1;
    in_operation   <= op;
    in_from_vertex <= f[VTX_W-1:0];
    in_to_vertex   <= t[VTX_W-1:0];
    in_edge_weight <= w[WEIGHT_BITS-1:0];
    do @(posedge clk); while (busy);
  endtask

  // sender pacing: random bursts, random gaps, some long gap-free stretches
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
  endtask

  // wait for every owed answer, then write the vertex count
  task automatic write_count(int value);
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // one random word; vertices mostly inside the active range
  task automatic random_word();
    int          n, f, t, pick;
    logic [2:0]  op;
    n    = sb.active_vertices();
    pick = $urandom_range(0, 99);
    if      (pick < 35) op = OP_SET;
    else if (pick < 47) op = OP_DEL;
    else if (pick < 62) op = OP_QUERY;
    else if (pick < 82) op = OP_SRCH;
    else if (pick < 95) op = OP_PRED;
    else                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    f = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    t = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
    send_word(op, f, t, $urandom_range(0, 16'hffff));
    pace();
  endtask

  initial begin
    int phase_counts[10] = '{64, 8, 1, 16, 0, 127, 5, 24, 64, 3};
    int phase_items[10]  = '{50, 90, 20, 90, 20, 40, 90, 90, 40, 90};
    rst_n          <= 1'b0;
    start          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    in_operation   <= '0;
    in_from_vertex <= '0;
    in_to_vertex   <= '0;
    in_edge_weight <= '0;
    idle_cycles    = 0;
    burst_left     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, all operations, special cases, full count
    send_word(OP_SET, 0, 63, 16'hffff);
    send_word(OP_SET, 63, 0, 16'h0000);
    send_word(OP_SET, 0, 63, 16'h1234);   // existing edge, weight only
    send_word(OP_QUERY, 0, 63, 0);
    send_word(OP_QUERY, 63, 63, 0);        // absent edge
    send_word(OP_DEL, 5, 6, 0);            // delete of an absent edge
    send_word(OP_DEL, 63, 0, 0);
    send_word(OP_SET, 1, 2, 16'haaaa);
    send_word(OP_SET, 2, 63, 16'h5555);
    send_word(OP_SET, 0, 1, 16'h8001);
    send_word(OP_SRCH, 0, 63, 0);          // 0 reaches 63 directly
    send_word(OP_SRCH, 0, 0, 0);           // source equals destination
    send_word(OP_SRCH, 63, 1, 0);          // no path
    send_word(OP_PRED, 63, 0, 0);
    send_word(OP_PRED, 2, 0, 0);
    send_word(OP_PRED, 0, 63, 0);
    send_word(OP_SPARE_LO, 63, 63, 16'hffff);
    send_word(OP_SPARE_MID, 0, 0, 0);
    send_word(OP_SPARE_HI, 63, 63, 16'hffff);
    write_count(8);
    // shrunk count: out-of-range checks, edges beyond the count stay counted
    send_word(OP_SET, 9, 1, 16'h7777);
    send_word(OP_SRCH, 1, 9, 0);
    send_word(OP_PRED, 9, 0, 0);
    send_word(OP_PRED, 7, 63, 0);          // only the from vertex is checked
    send_word(OP_QUERY, 0, 1, 0);

    for (int p = 0; p < 10; p++) begin
      write_count(phase_counts[p]);
      for (int i = 0; i < phase_items[p]; i++) random_word();
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d answers: set %0d, delete %0d, query %0d, search %0d (%0d found)",
             sb.checked, sb.op_seen[OP_SET], sb.op_seen[OP_DEL], sb.op_seen[OP_QUERY],
             sb.op_seen[OP_SRCH], sb.found_paths);
    $display("predecessor reads %0d, spare codes %0d, ten vertex count settings, %0d errors",
             sb.op_seen[OP_PRED],
             sb.op_seen[OP_SPARE_LO] + sb.op_seen[OP_SPARE_MID] + sb.op_seen[OP_SPARE_HI],
             sb.errors);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/gbfs_pkg.sv
rtl/core/gbfs_ram.sv
rtl/core/graph_bfs_path_search.sv
bench/tb_top.sv
